FILE: rtl/grid_min_path_sum_route_unit_macros.svh
// Assertion macros shared by the route unit
`ifndef GRID_MIN_PATH_SUM_ROUTE_UNIT_MACROS_SVH
`define GRID_MIN_PATH_SUM_ROUTE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define GMPSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define GMPSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gmpsr_pkg.sv
package gmpsr_pkg;

  // Field widths
  localparam int SUM_W      = 22;
  localparam int COST_W     = 16;
  localparam int MOVE_W     = 2;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

  // Move codes
  localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd0;
  localparam logic [MOVE_W-1:0] MOVE_DOWN  = 2'd1;
  localparam logic [MOVE_W-1:0] MOVE_NONE  = 2'd2;

  // Scan to traceback: bottom-right cell has just been taken
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] total;
  } scan_done_t;

endpackage

FILE: rtl/gmpsr_dir_ram.sv
module gmpsr_dir_ram
  import gmpsr_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/gmpsr_scan.sv
module gmpsr_scan
  import gmpsr_pkg::*;
#(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32,
  parameter int RW       = 5,
  parameter int CW       = 5,
  parameter int DAW      = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  cell_en,
  input  logic [COST_W-1:0]     cell_cost,
  output logic                  dir_we,
  output logic [DAW-1:0]        dir_waddr,
  output logic                  dir_wdata,
  output scan_done_t            done,
  output logic [RW-1:0]         last_row,
  output logic [CW-1:0]         last_col
);

  logic [CFG_DATA_W-1:0] grid_rows_r;
  logic [CFG_DATA_W-1:0] grid_cols_r;
  logic [RW-1:0]         row_r, row_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [SUM_W-1:0]      left_sum_r, left_sum_nxt;
  logic                  byp_r;
  logic [SUM_W-1:0]      byp_sum_r;
  logic [SUM_W-1:0]      col_q;
  logic [SUM_W-1:0]      col_mem [MAX_COLS];
  logic [SUM_W-1:0]      above_sum;
  logic [SUM_W-1:0]      base_sum;
  logic [SUM_W-1:0]      sum_val;
  logic                  from_left;
  logic                  at_last_col;
  logic                  at_last_row;
  logic                  restart;

  // Clamp dimensions: zero reads as one, above the maximum reads as the maximum
  always_comb begin
    if (grid_rows_r == '0) begin
      last_row = '0;
    end else if (grid_rows_r > CFG_DATA_W'(MAX_ROWS)) begin
      last_row = RW'(MAX_ROWS - 1);
    end else begin
      last_row = RW'(grid_rows_r - CFG_DATA_W'(1));
    end
    if (grid_cols_r == '0) begin
      last_col = '0;
    end else if (grid_cols_r > CFG_DATA_W'(MAX_COLS)) begin
      last_col = CW'(MAX_COLS - 1);
    end else begin
      last_col = CW'(grid_cols_r - CFG_DATA_W'(1));
    end
  end

  // Sum above comes from the column RAM, or forwarded when just written
  assign above_sum = byp_r ? byp_sum_r : col_q;

  // Pick the neighbour (ties go left), then one add
  always_comb begin
    if (row_r == '0) begin
      from_left = 1'b1;
    end else if (col_r == '0) begin
      from_left = 1'b0;
    end else begin
      from_left = (left_sum_r <= above_sum);
    end
    base_sum = from_left ? left_sum_r : above_sum;
    sum_val  = base_sum + {{(SUM_W-COST_W){1'b0}}, cell_cost};
  end

  assign at_last_col = (col_r == last_col);
  assign at_last_row = (row_r == last_row);
  assign restart     = cfg_we && (cfg_index == CFG_GRID_ROWS || cfg_index == CFG_GRID_COLS);

  // Position update in row-major order
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    left_sum_nxt = left_sum_r;
    if (restart) begin
      row_nxt      = '0;
      col_nxt      = '0;
      left_sum_nxt = '0;
    end else if (cell_en) begin
      if (!at_last_col) begin
        col_nxt      = col_r + CW'(1);
        left_sum_nxt = sum_val;
      end else begin
        col_nxt      = '0;
        left_sum_nxt = '0;
        row_nxt      = at_last_row ? '0 : row_r + RW'(1);
      end
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= CFG_DATA_W'(1);
      grid_cols_r <= CFG_DATA_W'(1);
      row_r       <= '0;
      col_r       <= '0;
      left_sum_r  <= '0;
      byp_r       <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_GRID_ROWS) begin
        grid_rows_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_GRID_COLS) begin
        grid_cols_r <= cfg_wdata;
      end
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      left_sum_r <= left_sum_nxt;
      byp_r      <= cell_en && (col_nxt == col_r);
    end
  end

  // Column sum RAM: read ahead at the next position, write the new sum
  always_ff @(posedge clk) begin
    if (cell_en) begin
      col_mem[col_r] <= sum_val;
    end
    col_q     <= col_mem[col_nxt];
    byp_sum_r <= sum_val;
  end

  // Direction bit per cell
  assign dir_we    = cell_en;
  assign dir_waddr = DAW'(row_r) * DAW'(MAX_COLS) + DAW'(col_r);
  assign dir_wdata = from_left;

  assign done.valid = cell_en && at_last_row && at_last_col;
  assign done.total = sum_val;

endmodule

FILE: rtl/gmpsr_trace.sv
module gmpsr_trace
  import gmpsr_pkg::*;
#(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32,
  parameter int RW       = 5,
  parameter int CW       = 5,
  parameter int DAW      = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scan_done_t        done,
  input  logic [RW-1:0]     last_row,
  input  logic [CW-1:0]     last_col,
  output logic              dir_re,
  output logic [DAW-1:0]    dir_raddr,
  input  logic              dir_rdata,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MOVE_W-1:0] out_move,
  output logic [SUM_W-1:0]  out_total,
  output logic              out_last
);

  localparam int SD  = MAX_ROWS + MAX_COLS;
  localparam int SAW = $clog2(SD);
  localparam int SPW = $clog2(SD + 1);

  typedef enum logic [5:0] {
    T_IDLE = 6'b000001,
    T_RD   = 6'b000010,
    T_DEC  = 6'b000100,
    T_POP  = 6'b001000,
    T_LOAD = 6'b010000,
    T_NONE = 6'b100000
  } trace_state_t;

  trace_state_t      state_r, state_nxt;
  logic [RW-1:0]     i_r;
  logic [CW-1:0]     j_r;
  logic [SPW-1:0]    sp_r;
  logic [SUM_W-1:0]  total_r;
  logic              stk_mem [SD];
  logic              stk_q;
  logic              go_left;
  logic [RW-1:0]     i_step;
  logic [CW-1:0]     j_step;
  logic              slot_free;
  logic              out_load;
  logic              out_valid_r;
  logic [MOVE_W-1:0] out_move_r;
  logic [SUM_W-1:0]  out_total_r;
  logic              out_last_r;

  // Step back one cell: edges are forced, interior follows the direction bit
  assign go_left = (i_r == '0) || ((j_r != '0) && dir_rdata);
  assign i_step  = go_left ? i_r : i_r - RW'(1);
  assign j_step  = go_left ? j_r - CW'(1) : j_r;

  assign slot_free = !out_valid_r || out_ready;
  assign out_load  = ((state_r == T_LOAD) || (state_r == T_NONE)) && slot_free;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: begin
        if (done.valid) begin
          state_nxt = (last_row == '0 && last_col == '0) ? T_NONE : T_RD;
        end
      end
      T_RD: state_nxt = T_DEC;
      T_DEC: state_nxt = (i_step == '0 && j_step == '0) ? T_POP : T_RD;
      T_POP: state_nxt = T_LOAD;
      T_LOAD: begin
        if (slot_free) begin
          state_nxt = (sp_r == SPW'(1)) ? T_IDLE : T_POP;
        end
      end
      T_NONE: begin
        if (slot_free) begin
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == T_IDLE && done.valid) begin
        sp_r <= '0;
      end else if (state_r == T_DEC) begin
        sp_r <= sp_r + SPW'(1);
      end else if (state_r == T_LOAD && slot_free) begin
        sp_r <= sp_r - SPW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Position and total
  always_ff @(posedge clk) begin
    if (state_r == T_IDLE && done.valid) begin
      i_r     <= last_row;
      j_r     <= last_col;
      total_r <= done.total;
    end else if (state_r == T_DEC) begin
      i_r <= i_step;
      j_r <= j_step;
    end
  end

  // Move stack RAM: pushed during traceback, popped in reverse
  always_ff @(posedge clk) begin
    if (state_r == T_DEC) begin
      stk_mem[SAW'(sp_r)] <= go_left ? MOVE_RIGHT[0] : MOVE_DOWN[0];
    end
    if (state_r == T_POP) begin
      stk_q <= stk_mem[SAW'(sp_r - SPW'(1))];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_total_r <= total_r;
      if (state_r == T_NONE) begin
        out_move_r <= MOVE_NONE;
        out_last_r <= 1'b1;
      end else begin
        out_move_r <= stk_q ? MOVE_DOWN : MOVE_RIGHT;
        out_last_r <= (sp_r == SPW'(1));
      end
    end
  end

  assign dir_re    = (state_r == T_RD);
  assign dir_raddr = DAW'(i_r) * DAW'(MAX_COLS) + DAW'(j_r);
  assign busy      = (state_r != T_IDLE);
  assign out_valid = out_valid_r;
  assign out_move  = out_move_r;
  assign out_total = out_total_r;
  assign out_last  = out_last_r;

endmodule

FILE: rtl/grid_min_path_sum_route_unit.sv
// Minimum right/down path sum over a grid, with route traceback.
//
// in_*  : one cell cost per transaction, row-major, grid_rows x grid_cols.
// out_* : one transaction per move of the cheapest route, start to end; each
//         carries the total cost, tlast marks the final move. A 1x1 grid gives
//         a single 'none' move.
// cfg_* : write grid_rows (index 0) or grid_cols (index 1); any such write
//         restarts the grid. Write only while the block is idle.
//
// Cells are taken one per cycle while in_tready is high: one add and one
// compare, with the column sum read ahead from a registered RAM. After the
// bottom-right cell in_tready drops: each move is traced by a direction RAM
// read, then a decision, and leaves the stack RAM by a pop, then an output
// load; all M = rows+cols-2 moves are loaded before the next grid is taken.
// A stalled receiver holds the output register and the stack pop waits.
// Reset sets both dimensions to 1, clears the position and empties the output.
`include "grid_min_path_sum_route_unit_macros.svh"

module grid_min_path_sum_route_unit
  import gmpsr_pkg::*;
#(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Cell costs
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] cell_cost
  // Route moves
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [1:0] move, [23:2] total_cost
  output logic                  out_tlast   // last_move
);

  localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DIR_DEP = MAX_ROWS * MAX_COLS;
  localparam int DAW     = (DIR_DEP > 1) ? $clog2(DIR_DEP) : 1;

  logic              cell_en;
  logic              dir_we;
  logic [DAW-1:0]    dir_waddr;
  logic              dir_wdata;
  logic              dir_re;
  logic [DAW-1:0]    dir_raddr;
  logic              dir_rdata;
  scan_done_t        done;
  logic [RW-1:0]     last_row;
  logic [CW-1:0]     last_col;
  logic              trace_busy;
  logic [MOVE_W-1:0] out_move;
  logic [SUM_W-1:0]  out_total;

  // Cells are refused while a route is being traced or emitted
  assign in_tready = !trace_busy;
  assign cell_en   = in_tvalid && in_tready;

  gmpsr_scan #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RW       (RW),
    .CW       (CW),
    .DAW      (DAW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cell_en   (cell_en),
    .cell_cost (in_tdata[COST_W-1:0]),
    .dir_we    (dir_we),
    .dir_waddr (dir_waddr),
    .dir_wdata (dir_wdata),
    .done      (done),
    .last_row  (last_row),
    .last_col  (last_col)
  );

  gmpsr_dir_ram #(
    .DEPTH (DIR_DEP),
    .AW    (DAW)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  gmpsr_trace #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RW       (RW),
    .CW       (CW),
    .DAW      (DAW)
  ) u_trace (
    .clk       (clk),
    .rst_n     (rst_n),
    .done      (done),
    .last_row  (last_row),
    .last_col  (last_col),
    .dir_re    (dir_re),
    .dir_raddr (dir_raddr),
    .dir_rdata (dir_rdata),
    .busy      (trace_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_move  (out_move),
    .out_total (out_total),
    .out_last  (out_tlast)
  );

  assign out_tdata = {out_total, out_move};

  // Checks
  `GMPSR_ASSERT_NEXT(a_done_starts_trace, done.valid, trace_busy, "grid end did not start traceback")
  `GMPSR_ASSERT_SAME(a_no_cell_in_trace, trace_busy, !done.valid, "grid end seen during traceback")
  `GMPSR_ASSERT_SAME(a_none_is_last, out_tvalid && out_tdata[MOVE_W-1:0] == MOVE_NONE, out_tlast, "none move not flagged last")

endmodule
